// ===== rtl/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// pva_pkg
// Shared widths, codes, defaults and beat types of the voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

  localparam int MODE_W       = 2;
  localparam int ORIGIN_TAG_W = 16;
  localparam int SOUND_W      = 9;
  localparam int PRIO_W       = 8;
  localparam int IDX_W        = 3;
  localparam int CH_W         = 3;
  localparam int CFG_W        = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_ORIGIN_BITS  = 16;

  localparam logic [MODE_W-1:0] MODE_ALLOC        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP_ORIGIN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP_CHANNEL = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [ORIGIN_TAG_W-1:0] origin_tag;
    logic [SOUND_W-1:0]      sound_id;
    logic [PRIO_W-1:0]       new_priority;
    logic [IDX_W-1:0]        channel_index;
  } item_t;

  typedef struct packed {
    logic               granted;
    logic [CH_W-1:0]    channel;
    logic               evicted;
    logic [SOUND_W-1:0] evicted_sound;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/pva_ifs.sv =====
// ----------------------------------------------------------------------------
// pva_ifs
// Request and response channels of the voice allocator (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface pva_req_if;
  logic                             valid;
  logic                             ready;
  logic [pva_pkg::MODE_W-1:0]       mode;
  logic [pva_pkg::ORIGIN_TAG_W-1:0] origin_tag;
  logic [pva_pkg::SOUND_W-1:0]      sound_id;
  logic [pva_pkg::PRIO_W-1:0]       new_priority;
  logic [pva_pkg::IDX_W-1:0]        channel_index;

  modport source (output valid, mode, origin_tag, sound_id, new_priority, channel_index,
                  input ready);
  modport sink   (input valid, mode, origin_tag, sound_id, new_priority, channel_index,
                  output ready);
endinterface

interface pva_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [pva_pkg::CH_W-1:0]    channel;
  logic                        evicted;
  logic [pva_pkg::SOUND_W-1:0] evicted_sound;

  modport source (output valid, granted, channel, evicted, evicted_sound, input ready);
  modport sink   (input valid, granted, channel, evicted, evicted_sound, output ready);
endinterface

`default_nettype wire

// ===== rtl/pva_ram.sv =====
// ----------------------------------------------------------------------------
// pva_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/pva_engine.sv =====
// ----------------------------------------------------------------------------
// pva_engine
// Channel table sequencer: scans the channel memory one entry per cycle,
// picks, evicts or frees a channel and, on allocation, writes the entry back.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_engine #(
  parameter int MAX_CHANNELS = pva_pkg::DEF_MAX_CHANNELS,
  parameter int ORIGIN_BITS  = pva_pkg::DEF_ORIGIN_BITS,
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CNT_W-1:0] n_chan,
  input  wire logic             item_valid,
  input  wire pva_pkg::item_t   item,
  output logic                  item_ready,
  output logic                  res_valid,
  output pva_pkg::result_t      res,
  input  wire logic             res_take
);

  localparam int AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EW  = ORIGIN_BITS + pva_pkg::PRIO_W + pva_pkg::SOUND_W;
  localparam int CW2 = pva_pkg::IDX_W + CNT_W;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_SCAN_FREE = 6'b000010,
    S_SCAN_PRIO = 6'b000100,
    S_STOP_ORG  = 6'b001000,
    S_STOP_CHK  = 6'b010000,
    S_DONE      = 6'b100000
  } state_t;

  state_t                      state;
  logic [MAX_CHANNELS-1:0]     valid;
  logic [ORIGIN_BITS-1:0]      org;
  logic [pva_pkg::PRIO_W-1:0]  prio;
  logic [pva_pkg::SOUND_W-1:0] sound;
  logic [CNT_W-1:0]            rd;
  logic [AW-1:0]               chk_idx;
  logic                        chk_live;

  logic [ORIGIN_BITS-1:0]      in_org;
  logic                        stop_ok;
  logic                        we;
  logic [AW-1:0]               raddr;
  logic [EW-1:0]               wdata;
  logic [EW-1:0]               rdata;
  logic [ORIGIN_BITS-1:0]      ent_org;
  logic [pva_pkg::PRIO_W-1:0]  ent_prio;
  logic [pva_pkg::SOUND_W-1:0] ent_sound;
  logic                        chk_busy;
  logic                        org_hit;
  logic                        hit;
  logic                        scan_end;

  // keep the low origin bits only
  assign in_org  = ORIGIN_BITS'({{ORIGIN_BITS{1'b0}}, item.origin_tag});
  assign stop_ok = (CW2'(item.channel_index) < CW2'(n_chan))
                   && valid[AW'(item.channel_index)];

  assign ent_org   = rdata[EW-1 -: ORIGIN_BITS];
  assign ent_prio  = rdata[pva_pkg::SOUND_W +: pva_pkg::PRIO_W];
  assign ent_sound = rdata[pva_pkg::SOUND_W-1:0];

  assign chk_busy = valid[chk_idx];
  assign org_hit  = ent_org == org;
  assign scan_end = !chk_live && (rd >= n_chan);

  always_comb begin
    unique case (state)
      S_SCAN_FREE: hit = chk_live && (!chk_busy || ((org != '0) && org_hit));
      S_SCAN_PRIO: hit = chk_live && (ent_prio >= prio);
      S_STOP_ORG:  hit = chk_live && chk_busy && org_hit;
      default:     hit = 1'b0;
    endcase
  end

  assign we    = hit && ((state == S_SCAN_FREE) || (state == S_SCAN_PRIO));
  assign wdata = {org, prio, sound};
  assign raddr = (state == S_IDLE) ? AW'(item.channel_index) : rd[AW-1:0];

  assign item_ready = state == S_IDLE;
  assign res_valid  = state == S_DONE;

  pva_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (chk_idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      rd       <= '0;
      chk_live <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            org      <= in_org;
            prio     <= item.new_priority;
            sound    <= item.sound_id;
            chk_idx  <= AW'(item.channel_index);
            rd       <= '0;
            chk_live <= 1'b0;
            priority if (item.mode == pva_pkg::MODE_ALLOC) begin
              state <= S_SCAN_FREE;
            end else if (item.mode == pva_pkg::MODE_STOP_ORIGIN) begin
              state <= S_STOP_ORG;
            end else if (item.mode == pva_pkg::MODE_STOP_CHANNEL && stop_ok) begin
              state <= S_STOP_CHK;
            end else begin
              res   <= '0;
              state <= S_DONE;
            end
          end
        end
        S_SCAN_FREE, S_SCAN_PRIO, S_STOP_ORG: begin
          if (hit) begin
            res.granted <= 1'b1;
            res.channel <= pva_pkg::CH_W'(chk_idx);
            state       <= S_DONE;
            if (state == S_STOP_ORG) begin
              valid[chk_idx]    <= 1'b0;
              res.evicted       <= 1'b1;
              res.evicted_sound <= ent_sound;
            end else begin
              valid[chk_idx]    <= 1'b1;
              res.evicted       <= chk_busy;
              res.evicted_sound <= chk_busy ? ent_sound : '0;
            end
          end else if (scan_end) begin
            if (state == S_SCAN_FREE) begin
              // no free or same-origin channel: look for one to steal
              rd       <= '0;
              chk_live <= 1'b0;
              state    <= S_SCAN_PRIO;
            end else begin
              res   <= '0;
              state <= S_DONE;
            end
          end else begin
            // issue the next read while checking the entry read last cycle
            chk_live <= rd < n_chan;
            chk_idx  <= rd[AW-1:0];
            if (rd < n_chan) begin
              rd <= CNT_W'(rd + 1'b1);
            end
          end
        end
        S_STOP_CHK: begin
          valid[chk_idx]    <= 1'b0;
          res.granted       <= 1'b1;
          res.channel       <= pva_pkg::CH_W'(chk_idx);
          res.evicted       <= 1'b1;
          res.evicted_sound <= ent_sound;
          state             <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/priority_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// priority_voice_allocator
// Voice-channel allocator with origin reuse and priority stealing.
//
// Requests arrive on req (valid/ready): allocate, stop by origin or stop one
// channel. Every request beat gives exactly one response beat on rsp with
// granted, channel, evicted and evicted_sound. cfg_we/cfg_wdata set the
// number of channels in use; write it only while no request is in flight.
// One request is worked at a time. The channel table sits in a RAM with one
// read port, scanned one entry per cycle. Allocate first scans for a free
// or same-origin entry and, failing that, makes a stealing pass; stop by
// origin scans for a live entry of that origin; stop channel reads only the
// entry named by channel_index.
// A finished response moves into the output register, and the next request
// is taken while it waits; if rsp is still stalled when the following
// response is done, that one holds in the engine and req.ready stays low.
// Reset frees all channels and sets the channel count to 8; there is no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_voice_allocator #(
  parameter int MAX_CHANNELS = pva_pkg::DEF_MAX_CHANNELS,
  parameter int ORIGIN_BITS  = pva_pkg::DEF_ORIGIN_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [pva_pkg::CFG_W-1:0]   cfg_wdata,
  pva_req_if.sink                          req,
  pva_rsp_if.source                        rsp
);

  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  logic [pva_pkg::CFG_W-1:0] cfg_n;
  logic [CNT_W-1:0]          n_chan;
  pva_pkg::item_t            item;
  pva_pkg::result_t          res;
  logic                      res_valid;
  logic                      res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_n <= pva_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_n <= cfg_wdata;
    end
  end

  // saturate the channel count at the table depth
  assign n_chan = (int'(cfg_n) > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) : CNT_W'(cfg_n);

  assign item.mode          = req.mode;
  assign item.origin_tag    = req.origin_tag;
  assign item.sound_id      = req.sound_id;
  assign item.new_priority  = req.new_priority;
  assign item.channel_index = req.channel_index;

  pva_engine #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .ORIGIN_BITS  (ORIGIN_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .n_chan     (n_chan),
    .item_valid (req.valid),
    .item       (item),
    .item_ready (req.ready),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  assign res_take = res_valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp.granted       <= res.granted;
      rsp.channel       <= res.channel;
      rsp.evicted       <= res.evicted;
      rsp.evicted_sound <= res.evicted_sound;
    end
  end

endmodule

`default_nettype wire
